>>> design/piecewise_linear_pdf_sampler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the piecewise-linear density sampler
// Concurrent checks that compile away when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_PDF_SAMPLER_ASSERT_SVH
`define PIECEWISE_LINEAR_PDF_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLPDF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("plpdf assertion failed");
`define PLPDF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   `PLPDF_ASSERT(lbl, clk, rst, (ante) |-> (cons))
`else
`define PLPDF_ASSERT(lbl, clk, rst, prop)
`define PLPDF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/plpdf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plpdf_pkg
// Field widths, codes and arithmetic unit widths of the sampler.
// ---------------------------------------------------------------------------
package plpdf_pkg;
   localparam int KIND_W  = 1;
   localparam int IDX_W   = 6;
   localparam int X_W     = 32;
   localparam int Y_W     = 31;
   localparam int U_W     = 32;
   localparam int NUM_W   = 7;
   localparam int AREA_W  = 48;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

   // bit-serial multiplier: A parallel, B one bit a cycle
   localparam int MUL_A_W   = 49;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // restoring divider: 96-bit dividend, 33-bit divisor, 64-bit quotient
   localparam int DIV_H_W   = 32;
   localparam int DIV_Q_W   = 64;
   localparam int DIV_D_W   = 33;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);
endpackage

>>> design/plpdf_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plpdf channel interfaces
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface plpdf_req_if;
   import plpdf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [IDX_W-1:0]        entry_index;
   logic signed [X_W-1:0]   entry_x;
   logic [Y_W-1:0]          entry_y;
   logic [U_W-1:0]          uniform;
   modport source (output valid, kind, entry_index, entry_x, entry_y, uniform, input ready);
   modport sink   (input valid, kind, entry_index, entry_x, entry_y, uniform, output ready);
endinterface

interface plpdf_rsp_if;
   import plpdf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [X_W-1:0]   sample_value;
   logic [IDX_W-1:0]        interval_index;
   modport source (output valid, sample_value, interval_index, input ready);
   modport sink   (input valid, sample_value, interval_index, output ready);
endinterface

interface plpdf_csr_if;
   import plpdf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [NUM_W-1:0]        data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> design/plpdf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plpdf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module plpdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule

>>> design/plpdf_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plpdf_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module plpdf_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plpdf_pkg::MUL_A_W-1:0]  a,
   input  logic [plpdf_pkg::MUL_B_W-1:0]  b,
   output logic                           done,
   output logic [plpdf_pkg::MUL_P_W-1:0]  product
);
   import plpdf_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [MUL_CNT_W-1:0]  cnt_ff;
   logic [MUL_A_W-1:0]    mcand_ff;
   logic [MUL_A_W-1:0]    hi_ff;
   logic [MUL_B_W-1:0]    lo_ff;
   logic [MUL_A_W:0]      sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // partial sum shifts down into the vacated multiplier bits
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         mcand_ff <= a;
         hi_ff    <= '0;
         lo_ff    <= b;
      end else if (busy_ff) begin
         hi_ff <= sum[MUL_A_W:1];
         lo_ff <= {sum[0], lo_ff[MUL_B_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};
endmodule

>>> design/plpdf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plpdf_div
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ---------------------------------------------------------------------------
module plpdf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plpdf_pkg::DIV_H_W-1:0]  num_hi,
   input  logic [plpdf_pkg::DIV_Q_W-1:0]  num_lo,
   input  logic [plpdf_pkg::DIV_D_W-1:0]  den,
   output logic                           done,
   output logic [plpdf_pkg::DIV_Q_W-1:0]  quotient
);
   import plpdf_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIV_D_W-1:0]    den_ff;
   logic [DIV_D_W-1:0]    rem_ff;
   logic [DIV_Q_W-1:0]    qs_ff;
   logic                  sat;
   logic [DIV_D_W:0]      sh;
   logic [DIV_D_W:0]      diff;
   logic                  ge;

   // quotient would not fit in 64 bits
   assign sat  = (den == '0) || ({1'b0, num_hi} >= den);
   assign sh   = {rem_ff, qs_ff[DIV_Q_W-1]};
   assign ge   = sh >= {1'b0, den_ff};
   assign diff = sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= !sat;
            done_ff <= sat;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         den_ff <= den;
         rem_ff <= DIV_D_W'(num_hi);
         qs_ff  <= sat ? '1 : num_lo;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_D_W-1:0] : sh[DIV_D_W-1:0];
         qs_ff  <= {qs_ff[DIV_Q_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = qs_ff;
endmodule

>>> design/piecewise_linear_pdf_sampler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// piecewise_linear_pdf_sampler
// Inverse transform sampling of a piecewise-linear density, Q16.16.
// ---------------------------------------------------------------------------
// Use: a request with kind = load writes table point entry_index (in
// ascending order from zero) and its running integral; it gives no response.
// A request with kind = sample gives one response: the sampled abscissa and
// the upper index of the interval that holds it. csr_bus writes the number
// of points in use (reset value 2); the user must write it only while the
// block is idle, which the block itself does not enforce. One request is
// worked on at a time. A load of point zero needs no multiply; any other
// load runs one bit-serial multiply. A sample runs three bit-serial
// multiplies, two divides, a bit-serial square root and a search that
// reads one integral per step through the RAM read ports (shared address).
// Reset returns the block to idle and drops any pending response; the table
// RAMs are not cleared and must be loaded before sampling. A finished
// response waits in the output register while the next request is taken;
// a sample then holds in its last step until that register is free.
// ---------------------------------------------------------------------------
module piecewise_linear_pdf_sampler #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   plpdf_req_if.sink   req_bus,
   plpdf_rsp_if.source rsp_bus,
   plpdf_csr_if.sink   csr_bus
);
   import plpdf_pkg::*;
`include "piecewise_linear_pdf_sampler_assert.svh"

   localparam int IW = $clog2(MAX_POINTS);
   localparam int NW = IW + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD_WR, S_LOAD_RD, S_LOAD_MUL, S_TOT_RD, S_TOT_ST, S_TOT_MUL,
      S_SRCH_RD, S_SRCH_CMP, S_PT_LO, S_PT_HI, S_PT_CAP, S_Y2_MUL, S_DR_MUL,
      S_Q_DIV, S_SQRT, S_DEN, S_T_DIV, S_FIN
   } state_type;

   state_type              state_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [IW-1:0]          idx_ff;
   logic [IW-1:0]          i_ff;
   logic signed [X_W-1:0]  req_x_ff;
   logic [Y_W-1:0]         req_y_ff;
   logic [U_W-1:0]         req_u_ff;
   logic                   ld_neg_ff;
   logic                   tot_neg_ff;
   logic signed [AREA_W:0] target_ff;
   logic signed [X_W-1:0]  x0_ff;
   logic [Y_W-1:0]         y0_ff;
   logic signed [AREA_W-1:0] c0_ff;
   logic signed [X_W:0]    dx_ff;
   logic signed [Y_W:0]    dy_ff;
   logic signed [AREA_W+1:0] r_ff;
   logic [2*Y_W-1:0]       y2_ff;
   logic [63:0]            sq_val_ff;
   logic [33:0]            sq_rem_ff;
   logic [31:0]            sq_root_ff;
   logic [4:0]             sq_cnt_ff;
   logic signed [X_W:0]    t_ff;
   logic                   rsp_valid_ff;
   logic signed [X_W-1:0]  rsp_value_ff;
   logic [IDX_W-1:0]       rsp_index_ff;

   // RAM ports
   logic                   x_we, cum_we, rd_en;
   logic [IW-1:0]          rd_addr;
   logic [X_W-1:0]         x_rd;
   logic [Y_W-1:0]         y_rd;
   logic [AREA_W-1:0]      cum_rd;
   logic [AREA_W-1:0]      cum_wdata;

   // arithmetic units
   logic                   mul_start, mul_done;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [MUL_P_W-1:0]     mul_prod;
   logic                   div_start, div_done;
   logic [DIV_H_W-1:0]     div_hi;
   logic [DIV_Q_W-1:0]     div_lo;
   logic [DIV_D_W-1:0]     div_den;
   logic [DIV_Q_W-1:0]     div_q;

   logic [NW-1:0]          n_eff, nm1;
   logic                   req_ok;
   logic                   fin_load;
   logic signed [X_W:0]    ld_dx;
   logic [X_W:0]           ld_dx_mag;
   logic [Y_W:0]           ld_ysum;
   logic [AREA_W-1:0]      ld_area;
   logic signed [AREA_W+1:0] ld_sum;
   logic [AREA_W-1:0]      cum_new;
   logic [AREA_W-1:0]      tot_mag;
   logic [AREA_W-1:0]      tm;
   logic signed [X_W:0]    cap_dx;
   logic [X_W:0]           dx_mag;
   logic [Y_W-1:0]         dy_mag;
   logic [MUL_A_W-1:0]     r_mag;
   logic                   disc_neg;
   logic [64:0]            disc_sum;
   logic [63:0]            disc;
   logic [34:0]            sq_sh, sq_trial, sq_diff;
   logic                   sq_ge;
   logic [DIV_D_W-1:0]     den_sum;
   logic [40:0]            tm41;
   logic signed [42:0]     t_raw, dx_wide, t_clamp;
   logic signed [X_W+1:0]  x_sum;
   logic signed [X_W-1:0]  x_sat;

   // ---------------- memories ----------------
   plpdf_ram #(.WIDTH(X_W), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock(clock), .we(x_we), .waddr(idx_ff), .wdata(req_x_ff),
      .re(rd_en), .raddr(rd_addr), .rdata(x_rd));

   plpdf_ram #(.WIDTH(Y_W), .DEPTH(MAX_POINTS)) u_y_ram (
      .clock(clock), .we(x_we), .waddr(idx_ff), .wdata(req_y_ff),
      .re(rd_en), .raddr(rd_addr), .rdata(y_rd));

   plpdf_ram #(.WIDTH(AREA_W), .DEPTH(MAX_POINTS)) u_cum_ram (
      .clock(clock), .we(cum_we), .waddr(idx_ff), .wdata(cum_wdata),
      .re(rd_en), .raddr(rd_addr), .rdata(cum_rd));

   plpdf_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_prod));

   plpdf_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num_hi(div_hi),
      .num_lo(div_lo), .den(div_den), .done(div_done), .quotient(div_q));

   // ---------------- point count ----------------
   always_comb begin
      if (num_ff < NUM_W'(2)) begin
         n_eff = NW'(2);
      end else if (32'(num_ff) > MAX_POINTS) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(num_ff);
      end
   end
   assign nm1    = n_eff - 1'b1;
   assign req_ok = 32'(req_bus.entry_index) < MAX_POINTS;

   // ---------------- load datapath ----------------
   assign ld_dx     = {req_x_ff[X_W-1], req_x_ff} - {x_rd[X_W-1], x_rd};
   assign ld_dx_mag = ld_dx[X_W] ? (X_W+1)'(-ld_dx) : (X_W+1)'(ld_dx);
   assign ld_ysum   = {1'b0, req_y_ff} + {1'b0, y_rd};
   assign ld_area   = mul_prod[AREA_W+16:17];
   assign ld_sum    = {{2{cum_rd[AREA_W-1]}}, cum_rd}
                    + (ld_neg_ff ? -$signed({2'b0, ld_area}) : $signed({2'b0, ld_area}));
   always_comb begin
      if (ld_sum[AREA_W+1:AREA_W-1] == 3'b000 || ld_sum[AREA_W+1:AREA_W-1] == 3'b111) begin
         cum_new = ld_sum[AREA_W-1:0];
      end else if (ld_sum[AREA_W+1]) begin
         cum_new = {1'b1, {(AREA_W-1){1'b0}}};
      end else begin
         cum_new = {1'b0, {(AREA_W-1){1'b1}}};
      end
   end

   // ---------------- sample datapath ----------------
   assign tot_mag = cum_rd[AREA_W-1] ? AREA_W'(-cum_rd) : cum_rd;
   assign tm      = mul_prod[AREA_W+31:32];
   assign cap_dx  = {x_rd[X_W-1], x_rd} - {x0_ff[X_W-1], x0_ff};
   assign dx_mag  = dx_ff[X_W] ? (X_W+1)'(-dx_ff) : (X_W+1)'(dx_ff);
   assign dy_mag  = dy_ff[Y_W] ? Y_W'(-dy_ff) : Y_W'(dy_ff);
   assign r_mag   = r_ff[AREA_W+1] ? MUL_A_W'(-r_ff) : MUL_A_W'(r_ff);
   assign disc_neg = (dy_ff[Y_W] ^ r_ff[AREA_W+1]) ^ dx_ff[X_W];
   assign disc_sum = {1'b0, div_q} + 65'(y2_ff);

   always_comb begin
      if (div_q == '0) begin
         disc = 64'(y2_ff);
      end else if (disc_neg) begin
         disc = (div_q >= 64'(y2_ff)) ? '0 : 64'(y2_ff) - div_q;
      end else begin
         disc = disc_sum[64] ? '1 : disc_sum[63:0];
      end
   end

   // two radicand bits per cycle
   assign sq_sh    = {sq_rem_ff[32:0], sq_val_ff[63:62]};
   assign sq_trial = {1'b0, sq_root_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;
   assign sq_diff  = sq_sh - sq_trial;
   assign den_sum  = {2'b0, y0_ff} + {1'b0, sq_root_ff};

   assign tm41    = (div_q > 64'h100_0000_0000) ? 41'h100_0000_0000 : div_q[40:0];
   assign t_raw   = r_ff[AREA_W+1] ? -$signed({2'b0, tm41}) : $signed({2'b0, tm41});
   assign dx_wide = 43'(dx_ff);
   always_comb begin
      t_clamp = t_raw;
      if (!dx_ff[X_W]) begin
         if (t_raw < 0) t_clamp = '0;
         else if (t_raw > dx_wide) t_clamp = dx_wide;
      end else begin
         if (t_raw > 0) t_clamp = '0;
         else if (t_raw < dx_wide) t_clamp = dx_wide;
      end
   end

   assign x_sum = (X_W+2)'(x0_ff) + (X_W+2)'(t_ff);
   always_comb begin
      if (x_sum[X_W+1:X_W-1] == 3'b000 || x_sum[X_W+1:X_W-1] == 3'b111) begin
         x_sat = x_sum[X_W-1:0];
      end else if (x_sum[X_W+1]) begin
         x_sat = {1'b1, {(X_W-1){1'b0}}};
      end else begin
         x_sat = {1'b0, {(X_W-1){1'b1}}};
      end
   end

   // ---------------- RAM and unit control ----------------
   assign x_we      = (state_ff == S_LOAD_WR);
   assign cum_we    = ((state_ff == S_LOAD_WR) && (idx_ff == '0))
                    || ((state_ff == S_LOAD_MUL) && mul_done);
   assign cum_wdata = (state_ff == S_LOAD_WR) ? '0 : cum_new;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         S_LOAD_WR: begin
            rd_en   = (idx_ff != '0);
            rd_addr = idx_ff - 1'b1;
         end
         S_TOT_RD: begin
            rd_en   = 1'b1;
            rd_addr = nm1[IW-1:0];
         end
         S_SRCH_RD: begin
            rd_en   = NW'(i_ff) < nm1;
            rd_addr = i_ff;
         end
         S_PT_LO: begin
            rd_en   = 1'b1;
            rd_addr = i_ff - 1'b1;
         end
         S_PT_HI: begin
            rd_en   = 1'b1;
            rd_addr = i_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_LOAD_RD: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(ld_dx_mag);
            mul_b     = MUL_B_W'(ld_ysum);
         end
         S_TOT_ST: begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(tot_mag);
            mul_b     = req_u_ff;
         end
         S_PT_CAP: begin
            mul_start = (cap_dx != '0);
            mul_a     = MUL_A_W'(y0_ff);
            mul_b     = MUL_B_W'(y0_ff);
         end
         S_Y2_MUL: begin
            mul_start = mul_done;
            mul_a     = r_mag;
            mul_b     = MUL_B_W'(dy_mag);
         end
         default: ;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_hi    = '0;
      div_lo    = '0;
      div_den   = '0;
      unique case (state_ff)
         S_DR_MUL: begin
            // dividend |dy*r| * 2^17
            div_start = mul_done;
            div_hi    = mul_prod[78:47];
            div_lo    = {mul_prod[46:0], 17'b0};
            div_den   = dx_mag;
         end
         S_DEN: begin
            div_start = (den_sum != '0);
            div_hi    = DIV_H_W'(r_mag[MUL_A_W-1:47]);
            div_lo    = {r_mag[46:0], 17'b0};
            div_den   = den_sum;
         end
         default: ;
      endcase
   end

   assign fin_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------- configuration register ----------------
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= NUM_W'(2);
      end else if (csr_bus.valid) begin
         num_ff <= csr_bus.data;
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= x_sat;
            rsp_index_ff <= IDX_W'(i_ff);
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  idx_ff   <= IW'(req_bus.entry_index);
                  req_x_ff <= req_bus.entry_x;
                  req_y_ff <= req_bus.entry_y;
                  req_u_ff <= req_bus.uniform;
                  if (req_bus.kind == KIND_SAMPLE) begin
                     state_ff <= S_TOT_RD;
                  end else if (req_ok) begin
                     state_ff <= S_LOAD_WR;
                  end
               end
            end
            S_LOAD_WR: begin
               state_ff <= (idx_ff == '0) ? S_IDLE : S_LOAD_RD;
            end
            S_LOAD_RD: begin
               ld_neg_ff <= ld_dx[X_W];
               state_ff  <= S_LOAD_MUL;
            end
            S_LOAD_MUL: begin
               if (mul_done) state_ff <= S_IDLE;
            end
            S_TOT_RD: begin
               state_ff <= S_TOT_ST;
            end
            S_TOT_ST: begin
               tot_neg_ff <= cum_rd[AREA_W-1];
               state_ff   <= S_TOT_MUL;
            end
            S_TOT_MUL: begin
               if (mul_done) begin
                  target_ff <= tot_neg_ff ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
                  i_ff      <= IW'(1);
                  state_ff  <= S_SRCH_RD;
               end
            end
            S_SRCH_RD: begin
               state_ff <= (NW'(i_ff) < nm1) ? S_SRCH_CMP : S_PT_LO;
            end
            S_SRCH_CMP: begin
               if ((AREA_W+1)'($signed(cum_rd)) > target_ff) begin
                  state_ff <= S_PT_LO;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SRCH_RD;
               end
            end
            S_PT_LO: begin
               state_ff <= S_PT_HI;
            end
            S_PT_HI: begin
               x0_ff    <= x_rd;
               y0_ff    <= y_rd;
               c0_ff    <= cum_rd;
               state_ff <= S_PT_CAP;
            end
            S_PT_CAP: begin
               dx_ff <= cap_dx;
               dy_ff <= $signed({1'b0, y_rd}) - $signed({1'b0, y0_ff});
               r_ff  <= (AREA_W+2)'(target_ff) - (AREA_W+2)'(c0_ff);
               t_ff  <= '0;
               state_ff <= (cap_dx == '0) ? S_FIN : S_Y2_MUL;
            end
            S_Y2_MUL: begin
               if (mul_done) begin
                  y2_ff    <= mul_prod[2*Y_W-1:0];
                  state_ff <= S_DR_MUL;
               end
            end
            S_DR_MUL: begin
               if (mul_done) state_ff <= S_Q_DIV;
            end
            S_Q_DIV: begin
               if (div_done) begin
                  sq_val_ff  <= disc;
                  sq_rem_ff  <= '0;
                  sq_root_ff <= '0;
                  sq_cnt_ff  <= '0;
                  state_ff   <= S_SQRT;
               end
            end
            S_SQRT: begin
               sq_val_ff  <= {sq_val_ff[61:0], 2'b00};
               sq_rem_ff  <= sq_ge ? sq_diff[33:0] : sq_sh[33:0];
               sq_root_ff <= {sq_root_ff[30:0], sq_ge};
               sq_cnt_ff  <= sq_cnt_ff + 1'b1;
               if (sq_cnt_ff == 5'd31) state_ff <= S_DEN;
            end
            S_DEN: begin
               state_ff <= (den_sum == '0) ? S_FIN : S_T_DIV;
            end
            S_T_DIV: begin
               if (div_done) begin
                  t_ff     <= (X_W+1)'(t_clamp);
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (fin_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.sample_value   = rsp_value_ff;
   assign rsp_bus.interval_index = rsp_index_ff;

   // ---------------- checks ----------------
   `PLPDF_ASSERT_IMPL(a_interval_range, clock, reset, state_ff == S_FIN, (i_ff != '0) && (NW'(i_ff) <= nm1))
   `PLPDF_ASSERT(a_rsp_loaded, clock, reset, fin_load |=> rsp_valid_ff)
   `PLPDF_ASSERT_IMPL(a_root_in_interval, clock, reset, (state_ff == S_FIN) && !dx_ff[X_W], !t_ff[X_W] && (t_ff <= dx_ff))
endmodule

>>> sim/piecewise_linear_pdf_sampler_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// piecewise_linear_pdf_sampler_test
// Self-checking bench: table loads and sample requests against a bit-exact
// predictor, with random gaps on both channels and several point counts.
// ---------------------------------------------------------------------------
module piecewise_linear_pdf_sampler_test;
   import plpdf_pkg::*;

   localparam int NPTS       = 64;
   localparam int SETTLE     = 600;
   localparam int WDOG_LIMIT = 20000;
   localparam int LONG_HOLD  = 3000;
   localparam int PHASE_REQS = 48;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  idx;
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [U_W-1:0]    u;
   } req_t;

   typedef struct {
      req_t              rq;
      bit                typed;
      logic [X_W-1:0]    val;
      logic [IDX_W-1:0]  ival;
   } row_t;

   typedef struct {
      logic [X_W-1:0]    val;
      logic [IDX_W-1:0]  ival;
   } sample_t;

   logic clock = 1'b0;
   logic reset;

   plpdf_req_if req_bus();
   plpdf_rsp_if rsp_bus();
   plpdf_csr_if csr_bus();

   piecewise_linear_pdf_sampler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   longint         tab_x [NPTS];
   logic [63:0]    tab_y [NPTS];
   longint         tab_area [NPTS];
   logic [NUM_W-1:0] points_in_use;

   sample_t        pending_samples [$];
   int             errors;
   bit             hold_off_req;

   function automatic logic [63:0] mag(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint sat_area(longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root, probe;
      root  = 0;
      probe = 64'h1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic void load_point(logic [IDX_W-1:0] i, logic [X_W-1:0] x,
                                      logic [Y_W-1:0] y);
      longint       dx;
      logic [127:0] prod;
      logic [63:0]  a;
      tab_x[i] = longint'($signed(x));
      tab_y[i] = 64'(y);
      if (i == 0) begin
         tab_area[0] = 0;
      end else begin
         dx   = tab_x[i] - tab_x[i-1];
         prod = 128'(mag(dx)) * 128'(tab_y[i] + tab_y[i-1]);
         a    = prod[80:17];
         tab_area[i] = sat_area(tab_area[i-1] + ((dx < 0) ? -$signed(a) : $signed(a)));
      end
   endfunction

   function automatic sample_t predict_sample(logic [U_W-1:0] u);
      int           n, i;
      longint       total, target, r, dx, dy, t, x, x0;
      logic [127:0] prod, quo;
      logic [63:0]  tm, y0, y2, q, d, s, den;
      logic [64:0]  sum;
      bit           neg;
      sample_t      res;
      n = points_in_use;
      if (n < 2) n = 2;
      if (n > NPTS) n = NPTS;
      total  = tab_area[n-1];
      prod   = 128'(mag(total)) * 128'(u);
      tm     = prod[95:32];
      target = (total < 0) ? -$signed(tm) : $signed(tm);
      i = 1;
      while (i < n - 1 && !(tab_area[i] > target)) i++;
      x0 = tab_x[i-1];
      y0 = tab_y[i-1];
      dx = tab_x[i] - x0;
      dy = longint'(tab_y[i]) - longint'(y0);
      r  = target - tab_area[i-1];
      t  = 0;
      if (dx != 0) begin
         y2   = y0 * y0;
         neg  = ((dy < 0) != (r < 0)) != (dx < 0);
         prod = (128'(mag(dy)) * 128'(mag(r))) << 17;
         quo  = prod / 128'(mag(dx));
         q    = (quo[127:64] != 0) ? '1 : quo[63:0];
         if (q == 0) begin
            d = y2;
         end else if (neg) begin
            d = (q >= y2) ? 64'd0 : y2 - q;
         end else begin
            sum = 65'(y2) + 65'(q);
            d   = sum[64] ? '1 : sum[63:0];
         end
         s   = int_sqrt(d);
         den = y0 + s;
         if (den != 0) begin
            quo = (128'(mag(r)) << 17) / 128'(den);
            tm  = (quo[127:64] != 0) ? '1 : quo[63:0];
            if (tm > (64'h1 << 40)) tm = 64'h1 << 40;
            t = (r < 0) ? -$signed(tm) : $signed(tm);
         end
         if (dx > 0) begin
            if (t < 0) t = 0;
            if (t > dx) t = dx;
         end else begin
            if (t > 0) t = 0;
            if (t < dx) t = dx;
         end
      end
      x = x0 + t;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      res.val  = x[31:0];
      res.ival = i[5:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_req(req_t rq, bit typed, logic [X_W-1:0] val,
                           logic [IDX_W-1:0] ival);
      int      gap;
      sample_t s;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= rq.kind;
      req_bus.entry_index <= rq.idx;
      req_bus.entry_x     <= rq.x;
      req_bus.entry_y     <= rq.y;
      req_bus.uniform     <= rq.u;
      do @(posedge clock); while (!req_bus.ready);
      if (rq.kind == KIND_LOAD) begin
         load_point(rq.idx, rq.x, rq.y);
      end else if (typed) begin
         s.val  = val;
         s.ival = ival;
         pending_samples.push_back(s);
      end else begin
         pending_samples.push_back(predict_sample(rq.u));
      end
   endtask

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_points(logic [NUM_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      points_in_use = v;
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [Y_W-1:0] rand_y();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return '0;
      if (p < 5) return Y_W'($urandom_range(0, 32'h30000));
      return Y_W'($urandom);
   endfunction

   task automatic rand_load(int i, ref logic [X_W-1:0] cursor);
      req_t rq;
      int   p;
      p = $urandom_range(0, 9);
      if (p < 6) cursor = cursor + $urandom_range(0, 32'h40000);
      else if (p < 8) cursor = $urandom;
      else if (p == 8) cursor = cursor - $urandom_range(0, 32'h20000);
      rq.kind = KIND_LOAD;
      rq.idx  = i[5:0];
      rq.x    = cursor;
      rq.y    = rand_y();
      rq.u    = $urandom;
      send_req(rq, 1'b0, '0, '0);
   endtask

   task automatic rand_sample();
      req_t rq;
      rq.kind = KIND_SAMPLE;
      rq.idx  = 6'($urandom);
      rq.x    = $urandom;
      rq.y    = Y_W'($urandom);
      rq.u    = $urandom;
      send_req(rq, 1'b0, '0, '0);
   endtask

   // receiver: random ready, plus one long hold-off on request
   int hold_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else if (hold_off_req) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= LONG_HOLD;
         hold_off_req  <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!rsp_bus.ready || $urandom_range(0, 9) < 2) begin
         if ($urandom_range(0, 19) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= $urandom_range(10, 60);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   always @(posedge clock) begin
      sample_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_bus.sample_value), 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_bus.sample_value !== want.val)
               report_mismatch("sample_value", 64'(rsp_bus.sample_value), 64'(want.val));
            if (rsp_bus.interval_index !== want.ival)
               report_mismatch("interval_index", 64'(rsp_bus.interval_index),
                               64'(want.ival));
         end
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // directed rows; typed expectations where they are obvious
   row_t directed [] = '{
      '{'{KIND_LOAD,   6'd0, 32'h0000_0000, 31'h0001_0000, 32'h0}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd1, 32'h0001_0000, 31'h0001_0000, 32'h0}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h0000_0000}, 1, 32'h0000_0000, 6'd1},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h8000_0000}, 1, 32'h0000_8000, 6'd1},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'hFFFF_FFFF}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd0, 32'h8000_0000, 31'h0000_0000, 32'h0}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'hFFFF_FFFF}, 0, '0, '0},
      // zero target at zero density: no root, sample stays at x0
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h0000_0000}, 1, 32'h8000_0000, 6'd1},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h4000_0000}, 0, '0, '0},
      // zero-width interval
      '{'{KIND_LOAD,   6'd0, 32'h0000_0005, 31'h7FFF_FFFF, 32'h0}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd1, 32'h0000_0005, 31'h0000_0000, 32'h0}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h1234_5678}, 1, 32'h0000_0005, 6'd1},
      // descending abscissa, negative area
      '{'{KIND_LOAD,   6'd0, 32'h7FFF_FFFF, 31'h0000_0100, 32'h0}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd1, 32'h8000_0000, 31'h7FFF_FFFF, 32'h0}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'hFFFF_FFFF}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h0000_0001}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd0, 32'hFFFF_0000, 31'h0003_0000, 32'h0}, 0, '0, '0},
      '{'{KIND_LOAD,   6'd1, 32'h0002_0000, 31'h0000_0000, 32'h0}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'hC000_0000}, 0, '0, '0},
      '{'{KIND_SAMPLE, 6'd0, 32'h0, 31'h0, 32'h5555_5555}, 0, '0, '0}
   };

   logic [NUM_W-1:0] settings [] = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd37, 7'd64};

   initial begin
      logic [X_W-1:0] cursor;
      int             done, k, p, ns;
      errors              = 0;
      points_in_use       = 7'd2;
      hold_off_req        = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_LOAD;
      req_bus.entry_index<= '0;
      req_bus.entry_x    <= '0;
      req_bus.entry_y    <= '0;
      req_bus.uniform    <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.data       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[j])
         send_req(directed[j].rq, directed[j].typed, directed[j].val, directed[j].ival);

      // whole table written once, so every later read is of a loaded entry
      cursor = $urandom;
      for (k = 0; k < NPTS; k++) rand_load(k, cursor);

      foreach (settings[ph]) begin
         quiesce();
         write_points(settings[ph]);
         if (ph == 2) hold_off_req = 1'b1;
         done = 0;
         while (done < PHASE_REQS) begin
            p = $urandom_range(0, 99);
            if (p < 70) begin
               ns = ($urandom_range(0, 3) == 0) ? NPTS - 1 : $urandom_range(1, 12);
               cursor = $urandom;
               for (k = 0; k <= ns; k++) rand_load(k, cursor);
               done = done + ns + 1;
               ns = $urandom_range(1, 6);
               for (k = 0; k < ns; k++) rand_sample();
               done = done + ns;
            end else if (p < 85) begin
               cursor = $urandom;
               rand_load($urandom_range(0, NPTS - 1), cursor);
               done++;
            end else begin
               rand_sample();
               done++;
            end
         end
      end

      quiesce();
      if (pending_samples.size() != 0)
         report_mismatch("responses left over", 64'(pending_samples.size()), 0);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+design
design/plpdf_pkg.sv
design/plpdf_if.sv
design/plpdf_ram.sv
design/plpdf_mul.sv
design/plpdf_div.sv
design/piecewise_linear_pdf_sampler.sv
sim/piecewise_linear_pdf_sampler_test.sv
